>>> sv/ppp_pkg.sv
// Shared types and constants for the perspective point projector.
`timescale 1ns / 1ps
`default_nettype none
package ppp_pkg;

   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 14;
   localparam int QUO_BITS   = 33;            // quotient bits, enough to see saturation
   localparam int DIV_LAT    = QUO_BITS + 2;  // entry stage, one stage per bit, result stage

   typedef logic [CSR_IDX_W-1:0] csr_idx_type;

   localparam csr_idx_type CSR_SCREEN_WIDTH  = 2'd0;
   localparam csr_idx_type CSR_SCREEN_HEIGHT = 2'd1;

   localparam logic MODE_LOAD  = 1'b0;
   localparam logic MODE_XFORM = 1'b1;

   function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
      logic signed [31:0] r;
      if (v > 64'sh0000_0000_7FFF_FFFF) begin
         r = 32'sh7FFF_FFFF;
      end else if (v < -64'sh0000_0000_8000_0000) begin
         r = 32'sh8000_0000;
      end else begin
         r = v[31:0];
      end
      return r;
   endfunction

endpackage
`default_nettype wire

>>> sv/ppp_ifs.sv
// Channel interfaces: point requests, screen results, register writes.
`timescale 1ns / 1ps
`default_nettype none
interface ppp_req_if;
   logic               valid;
   logic               ready;
   logic               mode;
   logic [3:0]         entry_index;
   logic signed [31:0] entry_value;
   logic signed [31:0] world_x;
   logic signed [31:0] world_y;
   logic signed [31:0] world_z;
   modport source (output valid, mode, entry_index, entry_value, world_x, world_y, world_z,
                   input ready);
   modport sink   (input valid, mode, entry_index, entry_value, world_x, world_y, world_z,
                   output ready);
endinterface

interface ppp_rsp_if;
   logic               valid;
   logic               ready;
   logic               visible;
   logic signed [31:0] screen_x;
   logic signed [31:0] screen_y;
   modport source (output valid, visible, screen_x, screen_y, input ready);
   modport sink   (input valid, visible, screen_x, screen_y, output ready);
endinterface

interface ppp_csr_if;
   logic                            valid;
   logic                            ready;
   logic [ppp_pkg::CSR_IDX_W-1:0]   index;
   logic [ppp_pkg::CSR_DATA_W-1:0]  data;
   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface
`default_nettype wire

>>> sv/ppp_div.sv
// Pipelined restoring divider: saturated Q fixed-point num / den, one quotient bit per stage.
`timescale 1ns / 1ps
`default_nettype none
module ppp_div #(
   parameter int NUM_W     = 50,
   parameter int FRAC_BITS = 16
) (
   input  wire logic                    clock,
   input  wire logic                    adv,
   input  wire logic signed [NUM_W-1:0] num,
   input  wire logic signed [NUM_W-1:0] den,   // positive
   output logic signed [31:0]           quo
);
   localparam int QB = ppp_pkg::QUO_BITS;
   localparam int DW = NUM_W + FRAC_BITS;

   logic [NUM_W-1:0] rem_ff [QB+1];
   logic [QB-1:0]    quo_ff [QB+1];
   logic [QB-1:0]    low_ff [QB+1];
   logic [NUM_W-1:0] den_ff [QB+1];
   logic             neg_ff [QB+1];
   logic             ovf_ff [QB+1];
   logic signed [31:0] res_ff, res_in;

   logic             neg_in;
   logic [NUM_W-1:0] mag_in;
   logic [DW-1:0]    dvd_in;
   logic [NUM_W-1:0] rem0_in;

   // entry: magnitude, high part of the shifted dividend, overflow check
   always_comb begin
      neg_in  = num[NUM_W-1];
      mag_in  = neg_in ? NUM_W'(-num) : NUM_W'(num);
      dvd_in  = {mag_in, {FRAC_BITS{1'b0}}};
      rem0_in = NUM_W'(dvd_in[DW-1:QB]);
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rem_ff[0] <= rem0_in;
         quo_ff[0] <= '0;
         low_ff[0] <= dvd_in[QB-1:0];
         den_ff[0] <= den;
         neg_ff[0] <= neg_in;
         ovf_ff[0] <= (rem0_in >= den);
      end
   end

   for (genvar i = 0; i < QB; i++) begin : g_step
      logic [NUM_W:0]   trial;
      logic [NUM_W:0]   diff;
      logic             ge;
      logic [NUM_W-1:0] rem_in;
      always_comb begin
         trial  = {rem_ff[i], low_ff[i][QB-1-i]};
         diff   = trial - {1'b0, den_ff[i]};
         ge     = trial >= {1'b0, den_ff[i]};
         rem_in = ge ? diff[NUM_W-1:0] : trial[NUM_W-1:0];
      end
      always_ff @(posedge clock) begin
         if (adv) begin
            rem_ff[i+1] <= rem_in;
            quo_ff[i+1] <= {quo_ff[i][QB-2:0], ge};
            low_ff[i+1] <= low_ff[i];
            den_ff[i+1] <= den_ff[i];
            neg_ff[i+1] <= neg_ff[i];
            ovf_ff[i+1] <= ovf_ff[i];
         end
      end
   end

   // sign and saturate
   always_comb begin
      if (neg_ff[QB]) begin
         if (ovf_ff[QB] || (quo_ff[QB] > QB'(33'h1_0000_0000 >> 1))) begin
            res_in = 32'sh8000_0000;
         end else begin
            res_in = 32'(-quo_ff[QB]);
         end
      end else begin
         if (ovf_ff[QB] || (quo_ff[QB][QB-1:31] != '0)) begin
            res_in = 32'sh7FFF_FFFF;
         end else begin
            res_in = quo_ff[QB][31:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         res_ff <= res_in;
      end
   end

   assign quo = res_ff;
endmodule
`default_nettype wire

>>> sv/perspective_point_projector.sv
// Top level of the perspective point projector.
`timescale 1ns / 1ps
`default_nettype none
// Projects world points through a 4x4 row-major Q16.16 view matrix onto the screen.
// A load transfer (mode 0) writes one matrix entry and gives no result; a transform
// transfer (mode 1) gives one result: visible, screen_x, screen_y. One item is taken
// every clock cycle; a transform passes the product and sum stages, the 33-stage
// quotient pipeline, the scale multiply and the result register. A load is seen by every
// transform that follows it, even the very next one. The whole pipeline stalls as one
// when the result is not taken; req ready is low only then. Register writes are
// always taken and must only happen while no transform is in flight.
module perspective_point_projector #(
   parameter int FRAC_BITS = 16
) (
   input  wire logic clock,
   input  wire logic reset,
   ppp_req_if.sink   req_ch,
   ppp_rsp_if.source rsp_ch,
   ppp_csr_if.sink   csr_ch
);
   localparam int PF = 64 - FRAC_BITS;      // floored product width
   localparam int SW = PF + 2;              // clip sum width
   localparam int MW = 50;                  // mapping sum width
   localparam int DL = ppp_pkg::DIV_LAT;
   localparam logic signed [SW-1:0] THR = SW'(((64'sd1 << FRAC_BITS) + 5) / 10);

   logic adv;
   logic req_xfer;

   // registers
   logic [13:0] width_ff, height_ff;
   logic signed [31:0] mat_ff [16];

   // stage 1: floored products
   logic              v1_ff;
   logic signed [PF-1:0] p_ff  [3][3];
   logic signed [31:0]   m3_ff [3];
   // stage 2: clip sums (x, y, w)
   logic              v2_ff;
   logic signed [SW-1:0] c_ff [3];
   // sideband through the divider
   logic v_sh_ff [DL];
   logic s_sh_ff [DL];
   // mapping multiply
   logic              vm_ff, sm_ff;
   logic signed [46:0] pmx_ff, pmy_ff;
   logic signed [31:0] nxm_ff, nym_ff;
   // result
   logic              rv_ff, rvis_ff;
   logic signed [31:0] rx_ff, ry_ff;

   logic signed [31:0] nx, ny;
   logic vis2;
   logic signed [SW-1:0] den2;

   // one stall for the whole pipeline; output register parts the two sides
   assign adv       = !rv_ff || rsp_ch.ready;
   assign req_xfer  = req_ch.valid && adv;
   assign req_ch.ready = adv;
   assign csr_ch.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= 14'd1920;
         height_ff <= 14'd1080;
      end else if (csr_ch.valid) begin
         case (csr_ch.index)
            ppp_pkg::CSR_SCREEN_WIDTH:  width_ff  <= csr_ch.data;
            ppp_pkg::CSR_SCREEN_HEIGHT: height_ff <= csr_ch.data;
            default: ;
         endcase
      end
   end

   // matrix writes land at the transfer edge
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 16; i++) mat_ff[i] <= '0;
      end else if (req_xfer && (req_ch.mode == ppp_pkg::MODE_LOAD)) begin
         mat_ff[req_ch.entry_index] <= req_ch.entry_value;
      end
   end

   // stage 1: multiply straight off the port; rows 0, 1 and 3
   for (genvar k = 0; k < 3; k++) begin : g_row
      localparam int ROW = (k == 2) ? 3 : k;
      logic signed [63:0] px, py, pz;
      always_comb begin
         px = 64'(req_ch.world_x) * 64'(mat_ff[ROW*4 + 0]);
         py = 64'(req_ch.world_y) * 64'(mat_ff[ROW*4 + 1]);
         pz = 64'(req_ch.world_z) * 64'(mat_ff[ROW*4 + 2]);
      end
      always_ff @(posedge clock) begin
         if (adv) begin
            p_ff[k][0] <= px[63:FRAC_BITS];   // arithmetic drop = floor
            p_ff[k][1] <= py[63:FRAC_BITS];
            p_ff[k][2] <= pz[63:FRAC_BITS];
            m3_ff[k]   <= mat_ff[ROW*4 + 3];
         end
      end
      // stage 2: exact row sum
      always_ff @(posedge clock) begin
         if (adv) begin
            c_ff[k] <= SW'(p_ff[k][0]) + SW'(p_ff[k][1]) + SW'(p_ff[k][2]) + SW'(m3_ff[k]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else if (adv) begin
         v1_ff <= req_xfer && (req_ch.mode == ppp_pkg::MODE_XFORM);
         v2_ff <= v1_ff;
      end
   end

   // visibility test; a hidden point divides by one to keep the divider tame
   assign vis2 = c_ff[2] >= THR;
   assign den2 = vis2 ? c_ff[2] : SW'(1);

   ppp_div #(.NUM_W(SW), .FRAC_BITS(FRAC_BITS)) u_div_x (
      .clock(clock), .adv(adv), .num(c_ff[0]), .den(den2), .quo(nx));
   ppp_div #(.NUM_W(SW), .FRAC_BITS(FRAC_BITS)) u_div_y (
      .clock(clock), .adv(adv), .num(c_ff[1]), .den(den2), .quo(ny));

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < DL; i++) v_sh_ff[i] <= 1'b0;
      end else if (adv) begin
         v_sh_ff[0] <= v2_ff;
         for (int i = 1; i < DL; i++) v_sh_ff[i] <= v_sh_ff[i-1];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s_sh_ff[0] <= vis2;
         for (int i = 1; i < DL; i++) s_sh_ff[i] <= s_sh_ff[i-1];
      end
   end

   // viewport scale multiply
   always_ff @(posedge clock) begin
      if (adv) begin
         pmx_ff <= 47'($signed({1'b0, width_ff}))  * 47'(nx);
         pmy_ff <= 47'($signed({1'b0, height_ff})) * 47'(ny);
         nxm_ff <= nx;
         nym_ff <= ny;
         sm_ff  <= s_sh_ff[DL-1];
      end
   end

   // offset, lone n term, saturate; hidden points read zero
   // every term is signed so the halving shifts stay arithmetic (floor)
   logic signed [MW-1:0] sx, sy, negy;
   always_comb begin
      negy = -MW'(pmy_ff);
      sx = (MW'(pmx_ff) >>> 1) + MW'(nxm_ff)
           + (MW'($signed({1'b0, width_ff})) << (FRAC_BITS - 1));
      sy = (negy >>> 1) + MW'(nym_ff)
           + (MW'($signed({1'b0, height_ff})) << (FRAC_BITS - 1));
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rvis_ff <= sm_ff;
         rx_ff   <= sm_ff ? ppp_pkg::sat32(64'(sx)) : 32'sd0;
         ry_ff   <= sm_ff ? ppp_pkg::sat32(64'(sy)) : 32'sd0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vm_ff <= 1'b0;
         rv_ff <= 1'b0;
      end else if (adv) begin
         vm_ff <= v_sh_ff[DL-1];
         rv_ff <= vm_ff;
      end
   end

   assign rsp_ch.valid    = rv_ff;
   assign rsp_ch.visible  = rvis_ff;
   assign rsp_ch.screen_x = rx_ff;
   assign rsp_ch.screen_y = ry_ff;
endmodule
`default_nettype wire

>>> sv/ppp_checker.sv
// Port-level checks for the perspective point projector, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
module ppp_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_valid,
   input wire logic        req_ready,
   input wire logic        rsp_valid,
   input wire logic        rsp_ready,
   input wire logic        rsp_visible,
   input wire logic [31:0] rsp_screen_x,
   input wire logic [31:0] rsp_screen_y
);
   a_rst_quiet: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid right after reset");

   a_ready_rule: assert property (@(posedge clock) disable iff (reset)
      req_ready == (!rsp_valid || rsp_ready))
      else $error("request ready does not follow the output stall");

   a_hidden_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_visible) |-> (rsp_screen_x == 32'd0 && rsp_screen_y == 32'd0))
      else $error("hidden point with nonzero coordinates");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_screen_x)
                                     && $stable(rsp_screen_y) && $stable(rsp_visible)))
      else $error("stalled result changed");
endmodule

bind perspective_point_projector ppp_checker u_ppp_checker (
   .clock(clock), .reset(reset),
   .req_valid(req_ch.valid), .req_ready(req_ch.ready),
   .rsp_valid(rsp_ch.valid), .rsp_ready(rsp_ch.ready),
   .rsp_visible(rsp_ch.visible),
   .rsp_screen_x(rsp_ch.screen_x), .rsp_screen_y(rsp_ch.screen_y)
);
`default_nettype wire

>>> tb/perspective_point_projector_tb.sv
// Self-checking testbench for the perspective point projector: matrix loads, projections, CSRs.
`timescale 1ns / 1ps
`default_nettype none
module perspective_point_projector_tb;

   localparam int  FRAC      = 16;
   localparam int  VIS_THR   = ((1 << FRAC) + 5) / 10;   // 0.1 in Q16.16
   localparam int  PIPE_LAT  = ppp_pkg::DIV_LAT + 3;     // transfer-to-result latency
   localparam int  DRAIN_GAP = PIPE_LAT + 8;
   localparam int  STALL_CAP = 4000;                     // cycles without any transfer
   localparam int  ONE_Q     = 1 << FRAC;
   // register indexes with no register behind them
   localparam ppp_pkg::csr_idx_type CSR_SPARE_LO = 2'd2;
   localparam ppp_pkg::csr_idx_type CSR_SPARE_HI = 2'd3;

   typedef struct packed {
      logic               visible;
      logic signed [31:0] screen_x;
      logic signed [31:0] screen_y;
   } screen_pt_type;

   logic clock = 1'b0;
   logic reset;

   ppp_req_if req_ch ();
   ppp_rsp_if rsp_ch ();
   ppp_csr_if csr_ch ();

   perspective_point_projector #(.FRAC_BITS(FRAC)) u_dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .csr_ch (csr_ch)
   );

   always #10 clock = ~clock;

   // predictor state: view matrix and viewport
   int          view_m [16];
   logic [13:0] vp_width;
   logic [13:0] vp_height;

   screen_pt_type pending_pts[$];
   int          error_count;
   int          load_count;
   int          xform_count;
   int          result_count;
   int          hidden_count;
   bit          idle_on;
   bit          stall_on;
   int          quiet_cycles;

   // ---------------------------------------------------------------- prediction
   function automatic longint sat_word(longint v);
      if (v > 64'sh7FFF_FFFF) return 64'sh7FFF_FFFF;
      if (v < -64'sh8000_0000) return -64'sh8000_0000;
      return v;
   endfunction

   // one row of the clip transform; each product floored to FRAC bits
   function automatic longint clip_row(int row, int x, int y, int z);
      longint acc;
      acc = (longint'(view_m[row*4+0]) * longint'(x)) >>> FRAC;
      acc += (longint'(view_m[row*4+1]) * longint'(y)) >>> FRAC;
      acc += (longint'(view_m[row*4+2]) * longint'(z)) >>> FRAC;
      acc += longint'(view_m[row*4+3]);
      return acc;
   endfunction

   // num * 2^FRAC / den, truncated toward zero, saturated; den > 0
   function automatic longint ndc_div(longint num, longint den);
      logic signed [127:0] wide_num;
      logic signed [127:0] wide_den;
      logic signed [127:0] quo;
      wide_num = num;
      wide_num = wide_num <<< FRAC;
      wide_den = den;
      quo = wide_num / wide_den;
      if (quo > 128'sh7FFF_FFFF) return 64'sh7FFF_FFFF;
      if (quo < -128'sh8000_0000) return -64'sh8000_0000;
      return longint'(quo);
   endfunction

   function automatic screen_pt_type project_point(int x, int y, int z);
      screen_pt_type pt;
      longint cx, cy, cw, nx, ny, sx, sy, wl, hl;
      cx = clip_row(0, x, y, z);
      cy = clip_row(1, x, y, z);
      cw = clip_row(3, x, y, z);
      pt = '0;
      if (cw >= VIS_THR) begin
         wl = longint'(vp_width);
         hl = longint'(vp_height);
         nx = ndc_div(cx, cw);
         ny = ndc_div(cy, cw);
         sx = ((wl * nx) >>> 1) + nx + (wl <<< (FRAC - 1));
         sy = ((-(hl * ny)) >>> 1) + ny + (hl <<< (FRAC - 1));
         pt.visible  = 1'b1;
         pt.screen_x = 32'(sat_word(sx));
         pt.screen_y = 32'(sat_word(sy));
      end
      return pt;
   endfunction

   // ---------------------------------------------------------------- checking
   task automatic report_mismatch(string what, longint got, longint want);
      $display("mismatch %s: got %0d, expected %0d (result %0d)", what, got, want,
               result_count);
      error_count++;
   endtask

   always @(posedge clock) begin
      screen_pt_type want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (pending_pts.size() == 0) begin
            $display("unexpected result transfer: visible %0b x %0d y %0d",
                     rsp_ch.visible, rsp_ch.screen_x, rsp_ch.screen_y);
            error_count++;
         end else begin
            want = pending_pts.pop_front();
            if (rsp_ch.visible !== want.visible)
               report_mismatch("visible", rsp_ch.visible, want.visible);
            if (rsp_ch.screen_x !== want.screen_x)
               report_mismatch("screen_x", rsp_ch.screen_x, want.screen_x);
            if (rsp_ch.screen_y !== want.screen_y)
               report_mismatch("screen_y", rsp_ch.screen_y, want.screen_y);
            if (!want.visible) hidden_count++;
         end
         result_count++;
      end
   end

   // result-side backpressure in bursts
   int stall_left;
   always @(posedge clock) begin
      if (stall_left > 0) begin
         stall_left <= stall_left - 1;
         rsp_ch.ready <= (stall_left == 1);
      end else if (stall_on && $urandom_range(0, 9) == 0) begin
         stall_left <= $urandom_range(1, 11);
         rsp_ch.ready <= 1'b0;
      end else begin
         rsp_ch.ready <= 1'b1;
      end
   end

   // watchdog: any transfer on any channel resets the count
   always @(posedge clock) begin
      if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) ||
          (csr_ch.valid && csr_ch.ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= STALL_CAP) begin
            $display("watchdog: no transfer for %0d cycles", STALL_CAP);
            $display("[FAIL] regression broken");
            $finish;
         end
      end
   end

   // ---------------------------------------------------------------- stimulus
   // one request transfer; an idle burst may come first
   task automatic send_item(logic mode, logic [3:0] idx, int value, int x, int y, int z);
      if (idle_on && $urandom_range(0, 5) == 0) begin
         req_ch.valid <= 1'b0;
         repeat ($urandom_range(1, 11)) @(posedge clock);
      end
      req_ch.valid       <= 1'b1;
      req_ch.mode        <= mode;
      req_ch.entry_index <= idx;
      req_ch.entry_value <= value;
      req_ch.world_x     <= x;
      req_ch.world_y     <= y;
      req_ch.world_z     <= z;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      // transfer taken at this edge
      if (mode == ppp_pkg::MODE_LOAD) begin
         view_m[idx] = value;
         load_count++;
      end else begin
         pending_pts.insert(pending_pts.size(), project_point(x, y, z));
         xform_count++;
      end
   endtask

   task automatic load_entry(int idx, int value);
      send_item(ppp_pkg::MODE_LOAD, 4'(idx), value, $urandom, $urandom, $urandom);
   endtask

   task automatic xform_point(int x, int y, int z);
      send_item(ppp_pkg::MODE_XFORM, 4'($urandom), $urandom, x, y, z);
   endtask

   task automatic drain_results();
      req_ch.valid <= 1'b0;
      while (pending_pts.size() != 0) @(posedge clock);
      repeat (DRAIN_GAP) @(posedge clock);
   endtask

   // register write, only with the pipeline drained
   task automatic write_csr(ppp_pkg::csr_idx_type idx, logic [13:0] value);
      drain_results();
      csr_ch.valid <= 1'b1;
      csr_ch.index <= idx;
      csr_ch.data  <= value;
      @(posedge clock);
      while (!csr_ch.ready) @(posedge clock);
      csr_ch.valid <= 1'b0;
      if (idx == ppp_pkg::CSR_SCREEN_WIDTH) vp_width = value;
      else if (idx == ppp_pkg::CSR_SCREEN_HEIGHT) vp_height = value;
   endtask

   // Q16.16 word: mostly modest values, sometimes extremes or raw bits
   function automatic int rand_q(int span);
      case ($urandom_range(0, 9))
         0: return $urandom;
         1: return 32'sh8000_0000;
         2: return 32'sh7FFF_FFFF;
         default: return ((int'($urandom_range(0, 2*span)) - span) <<< FRAC)
                         + int'($urandom_range(0, ONE_Q - 1));
      endcase
   endfunction

   // perspective-like matrix: small rotation/scale rows, w = z + dist
   task automatic load_scene();
      int r, c;
      for (r = 0; r < 3; r++)
         for (c = 0; c < 4; c++)
            load_entry(r*4+c, ($urandom_range(0, 9) == 0) ? rand_q(30000)
                       : int'($urandom_range(0, 8*ONE_Q)) - 4*ONE_Q);
      load_entry(12, int'($urandom_range(0, ONE_Q/4)) - ONE_Q/8);
      load_entry(13, int'($urandom_range(0, ONE_Q/4)) - ONE_Q/8);
      load_entry(14, ONE_Q + int'($urandom_range(0, ONE_Q)) - ONE_Q/2);
      load_entry(15, int'($urandom_range(0, 20*ONE_Q)) - 2*ONE_Q);
   endtask

   task automatic test_reset_state();
      // zero matrix after reset: w = 0, never visible
      xform_point(32'sh7FFF_FFFF, 32'sh8000_0000, 0);
      xform_point(0, 0, 0);
   endtask

   task automatic test_visibility_threshold();
      int k;
      for (k = 0; k < 16; k++) load_entry(k, 0);
      load_entry(0, ONE_Q);
      load_entry(5, -ONE_Q);
      load_entry(3, 3*ONE_Q);
      load_entry(15, VIS_THR - 1);          // just below 0.1
      xform_point(ONE_Q, ONE_Q, ONE_Q);
      load_entry(15, VIS_THR);              // exactly 0.1, tiny w saturates screen_x
      xform_point(ONE_Q, -ONE_Q, 0);
      load_entry(15, 32'sh8000_0000);       // large negative w
      xform_point(0, 0, 0);
   endtask

   task automatic test_extreme_fields();
      load_entry(15, ONE_Q);
      load_entry(0, 32'sh7FFF_FFFF);
      load_entry(1, 32'sh8000_0000);
      load_entry(2, 32'sh7FFF_FFFF);
      load_entry(4, 32'sh8000_0000);
      load_entry(14, 32'sh7FFF_FFFF);
      xform_point(32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh7FFF_FFFF);
      xform_point(32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000);
      xform_point(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 0);
   endtask

   task automatic test_viewport_extremes();
      write_csr(ppp_pkg::CSR_SCREEN_WIDTH, 14'd0);
      write_csr(ppp_pkg::CSR_SCREEN_HEIGHT, 14'h3FFF);
      xform_point(ONE_Q, -ONE_Q, ONE_Q);
      write_csr(ppp_pkg::CSR_SCREEN_WIDTH, 14'd8192);
      write_csr(ppp_pkg::CSR_SCREEN_HEIGHT, 14'd1);
      write_csr(CSR_SPARE_LO, 14'h3FFF);    // unused index, ignored
      write_csr(CSR_SPARE_HI, 14'h1555);
      xform_point(-ONE_Q, ONE_Q/2, ONE_Q);
   endtask

   task automatic test_random_scenes(int budget, bit with_idle);
      int sent, n, k;
      idle_on  = with_idle;
      stall_on = with_idle;
      sent = 0;
      while (sent < budget) begin
         case ($urandom_range(0, 9))
            0: begin
               write_csr(ppp_pkg::CSR_SCREEN_WIDTH, 14'($urandom_range(0, 3) == 0 ? $urandom
                         : $urandom_range(1, 8192)));
               write_csr(ppp_pkg::CSR_SCREEN_HEIGHT, 14'($urandom_range(0, 3) == 0 ? $urandom
                         : $urandom_range(1, 8192)));
            end
            1: begin
               // noise: scattered raw loads and raw points
               for (k = 0; k < 6; k++) begin
                  if ($urandom_range(0, 1)) load_entry($urandom_range(0, 15), $urandom);
                  else xform_point($urandom, $urandom, $urandom);
               end
               sent += 6;
            end
            2: begin
               // broken scene: only part of the matrix replaced
               for (k = 0; k < 4; k++) load_entry($urandom_range(0, 15), rand_q(8));
               sent += 4;
            end
            default: begin
               load_scene();
               sent += 16;
            end
         endcase
         n = $urandom_range(5, 20);
         for (k = 0; k < n; k++) begin
            if ($urandom_range(0, 11) == 0) load_entry($urandom_range(0, 15), rand_q(4));
            xform_point(rand_q(200), rand_q(200), rand_q(100));
         end
         sent += n;
      end
   endtask

   initial begin
      for (int k = 0; k < 16; k++) view_m[k] = 0;
      vp_width     = 14'd1920;
      vp_height    = 14'd1080;
      error_count  = 0;
      load_count   = 0;
      xform_count  = 0;
      result_count = 0;
      hidden_count = 0;
      idle_on      = 1'b0;
      stall_on     = 1'b0;
      reset              <= 1'b1;
      req_ch.valid       <= 1'b0;
      req_ch.mode        <= ppp_pkg::MODE_LOAD;
      req_ch.entry_index <= '0;
      req_ch.entry_value <= '0;
      req_ch.world_x     <= '0;
      req_ch.world_y     <= '0;
      req_ch.world_z     <= '0;
      csr_ch.valid       <= 1'b0;
      csr_ch.index       <= ppp_pkg::CSR_SCREEN_WIDTH;
      csr_ch.data        <= '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_reset_state();
      test_visibility_threshold();
      test_extreme_fields();
      test_viewport_extremes();
      write_csr(ppp_pkg::CSR_SCREEN_WIDTH, 14'd1920);
      write_csr(ppp_pkg::CSR_SCREEN_HEIGHT, 14'd1080);
      test_random_scenes(1000, 1'b1);
      // final stretch at full rate, no idling on either side
      test_random_scenes(250, 1'b0);

      drain_results();
      $display("covered %0d loads and %0d transforms; %0d results, %0d not visible",
               load_count, xform_count, result_count, hidden_count);
      $display("viewport extremes, unused register indexes and random backpressure exercised");
      if (error_count == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("%0d mismatches", error_count);
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
`default_nettype wire
